### design/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg: shared types and constants of the altitude complementary filter
// Event codes, gain constants and the serial multiplier command struct.
// ----------------------------------------------------------------------------
package acf_pkg;

    typedef enum logic [1:0] {
        ACT_OBSERVE  = 2'd0,
        ACT_INERTIAL = 2'd1,
        ACT_FIX      = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_OBS_RATE     = 3'd0,
        CFG_FLOW_TIMEOUT = 3'd1,
        CFG_FLOW_MAX     = 3'd2,
        CFG_IMU_DT       = 3'd3,
        CFG_FIX_DT       = 3'd4
    } cfg_index_t;

    localparam int MUL_W  = 40;  // signed multiplicand width
    localparam int MULT_W = 18;  // unsigned multiplier width

    localparam logic [MULT_W-1:0] GAIN_A_BARO = 18'd52429;
    localparam logic [MULT_W-1:0] GAIN_A_FLOW = 18'd104858;
    localparam logic [MULT_W-1:0] GAIN_B      = 18'd32768;
    localparam logic [MULT_W-1:0] GAIN_C      = 18'd13107;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_W-1:0]  a;
        logic        [MULT_W-1:0] b;
    } mul_cmd_t;

    typedef struct packed {
        logic                       done;
        logic signed [MUL_W+MULT_W-1:0] p;
    } mul_rsp_t;

endpackage

### design/acf_mul.sv
// ----------------------------------------------------------------------------
// acf_mul: bit-serial signed by unsigned multiplier
// Shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module acf_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  acf_pkg::mul_cmd_t cmd,
    output acf_pkg::mul_rsp_t rsp
);
    import acf_pkg::*;

    localparam int PW = MUL_W + MULT_W;

    logic signed [PW-1:0]   acc_reg, acc_next;
    logic signed [PW-1:0]   mcand_reg, mcand_next;
    logic [MULT_W-1:0]      mplier_reg, mplier_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (cmd.start) begin
            acc_next    = '0;
            mcand_next  = PW'(cmd.a);
            mplier_next = cmd.b;
            cnt_next    = 5'(MULT_W);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> !busy_reg) else $error("done while busy");
    a_cnt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !cmd.start |=> cnt_reg == $past(cnt_reg))
        else $error("counter moved while idle");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done) else $error("done longer than one cycle");

endmodule

### design/altitude_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// altitude_complementary_filter_top: third-order altitude complementary filter
// Fuses barometer and optical-flow height with vertical acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one event per transaction (observation, inertial
//   or correction, chosen by s_action); each event returns exactly one
//   result transaction on the m_ channel with speed, height and the path flag.
//   Write registers via cfg_we/cfg_index/cfg_data while idle; not enforced.
// Processing:
//   Every product goes through one bit-serial multiplier: a start state, the
//   shift steps of the multiplier and a wait state that takes the product.
//   Observation events use one product, inertial events two, correction
//   events seven and no-op events none. One event is processed at a time;
//   s_ready is high while no event is at work and the output register is
//   free or being drained.
// Reset:
//   aresetn (synchronous, active low) clears the filter state, loads the
//   register defaults and arms the reset request taken on the first
//   correction event.
// Stall:
//   A result waits in the output register while m_ready is low; the block
//   holds further events until it is taken.
// ----------------------------------------------------------------------------
module altitude_complementary_filter_top #(
    parameter int FRAC_BITS      = 8,
    parameter int GROUND_SAMPLES = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [20:0] s_baro_alt_cm,
    input  logic [15:0]        s_flow_alt_cm,
    input  logic               s_flow_ok,
    input  logic signed [23:0] s_z_accel,
    input  logic               s_armed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_z_speed,
    output logic signed [31:0] m_z_position,
    output logic               m_using_baro,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import acf_pkg::*;

    localparam int PW = MUL_W + MULT_W;
    localparam logic signed [31:0] VLIM = 32'sd500 <<< FRAC_BITS;
    localparam logic signed [31:0] ALIM = 32'sd50 <<< FRAC_BITS;
    localparam logic signed [31:0] S32MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32MIN = 32'sh80000000;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_WAIT = 8'b0000_0100,
        ST_OUT  = 8'b0000_1000
    } state_t;

    // configuration
    logic [9:0]  obs_rate_reg;
    logic [15:0] flow_timeout_reg, flow_max_reg, imu_dt_reg, fix_dt_reg;

    // filter state
    logic [3:0]         ground_count_reg;
    logic signed [31:0] ground_cm_reg, baro_h_reg, prev_baro_reg;
    logic [15:0]        prev_flow_reg, flow_held_reg, bad_cnt_reg;
    logic               baro_latched_reg, flow_gains_reg, reset_pend_reg;
    logic signed [31:0] vref_reg, href_reg, evel_reg, eh_reg, ca_reg;
    // height correction can exceed 32 bits when the references are far apart
    logic signed [MUL_W-1:0] fh_reg;
    logic signed [31:0] fv_reg, t_reg;

    state_t      state_reg;
    logic [3:0]  step_reg;
    logic [1:0]  act_reg;
    logic        armed_reg;
    logic signed [23:0] accel_reg;
    logic signed [31:0] dvf_reg;

    mul_cmd_t cmd;
    mul_rsp_t rsp;

    acf_mul u_mul (.aclk(aclk), .aresetn(aresetn), .cmd(cmd), .rsp(rsp));

    function automatic logic signed [31:0] sat(input logic signed [PW-1:0] x);
        if (x > PW'(S32MAX)) return S32MAX;
        if (x < PW'(S32MIN)) return S32MIN;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] clampl(input logic signed [PW-1:0] x,
                                                  input logic signed [31:0] l);
        if (x > PW'(l)) return l;
        if (x < -PW'(l)) return -l;
        return x[31:0];
    endfunction

    // round half up and floor shift of a Q.16 product
    logic signed [PW-1:0] rnd;
    assign rnd = (rsp.p + PW'(32768)) >>> 16;

    // multiplier operand per step
    always_comb begin
        cmd.start = (state_reg == ST_MUL);
        cmd.a = '0;
        cmd.b = '0;
        if (act_reg == ACT_OBSERVE) begin
            cmd.a = MUL_W'(dvf_reg);
            cmd.b = MULT_W'(obs_rate_reg);
        end else if (act_reg == ACT_INERTIAL) begin
            cmd.b = MULT_W'(imu_dt_reg);
            if (step_reg == 4'd0) cmd.a = MUL_W'(accel_reg);
            else                  cmd.a = MUL_W'(evel_reg);
        end else begin
            unique case (step_reg)
                4'd0: begin cmd.a = MUL_W'(vref_reg); cmd.b = MULT_W'(fix_dt_reg); end
                4'd1: begin
                    cmd.a = MUL_W'(href_reg) - MUL_W'(eh_reg);
                    cmd.b = flow_gains_reg ? GAIN_A_FLOW : GAIN_A_BARO;
                end
                4'd2: begin
                    cmd.a = MUL_W'(vref_reg) - MUL_W'(evel_reg);
                    cmd.b = GAIN_B;
                end
                4'd3: begin cmd.a = MUL_W'(fv_reg); cmd.b = GAIN_C; end
                4'd4: begin cmd.a = MUL_W'(t_reg); cmd.b = MULT_W'(fix_dt_reg); end
                4'd5: begin cmd.a = fh_reg; cmd.b = MULT_W'(fix_dt_reg); end
                default: begin
                    cmd.a = MUL_W'(ca_reg) + MUL_W'(fv_reg);
                    cmd.b = MULT_W'(fix_dt_reg);
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid || m_ready);

    logic [3:0] last_step;
    always_comb begin
        unique case (act_reg)
            ACT_INERTIAL: last_step = 4'd1;
            ACT_FIX:      last_step = 4'd6;
            default:      last_step = 4'd0;
        endcase
    end

    // observation front end, combinational on the accepted item
    logic signed [31:0] bh_new;
    logic [15:0]        fh_new;
    logic [16:0]        bad_new;
    logic               latch_new;
    logic signed [PW-1:0] dvb;
    always_comb begin
        bh_new = baro_h_reg;
        if (ground_count_reg == 4'd0) begin
            bh_new = sat(PW'(s_baro_alt_cm) - PW'(ground_cm_reg));
        end
        latch_new = baro_latched_reg;
        if (s_flow_alt_cm < flow_max_reg) begin
            fh_new  = s_flow_alt_cm;
            bad_new = '0;
        end else begin
            fh_new  = flow_held_reg;
            bad_new = (bad_cnt_reg == 16'hffff) ? 17'hffff : 17'(bad_cnt_reg) + 17'd1;
            if (bad_new > 17'(flow_timeout_reg)) latch_new = 1'b1;
        end
        dvb = PW'(bh_new) - PW'(prev_baro_reg);
    end

    logic signed [PW-1:0] vmul;   // diff * rate * 2^FRAC
    assign vmul = rsp.p <<< FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_rate_reg     <= 10'd50;
            flow_timeout_reg <= 16'd150;
            flow_max_reg     <= 16'd200;
            imu_dt_reg       <= 16'd66;
            fix_dt_reg       <= 16'd131;
            ground_count_reg <= 4'(GROUND_SAMPLES);
            ground_cm_reg    <= '0;
            baro_h_reg       <= '0;
            prev_baro_reg    <= '0;
            prev_flow_reg    <= '0;
            flow_held_reg    <= '0;
            bad_cnt_reg      <= '0;
            baro_latched_reg <= 1'b0;
            flow_gains_reg   <= 1'b0;
            reset_pend_reg   <= 1'b1;
            vref_reg         <= '0;
            href_reg         <= '0;
            evel_reg         <= '0;
            eh_reg           <= '0;
            ca_reg           <= '0;
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            m_valid          <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_OBS_RATE:     obs_rate_reg     <= cfg_data[9:0];
                    CFG_FLOW_TIMEOUT: flow_timeout_reg <= cfg_data;
                    CFG_FLOW_MAX:     flow_max_reg     <= cfg_data;
                    CFG_IMU_DT:       imu_dt_reg       <= cfg_data;
                    CFG_FIX_DT:       fix_dt_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        act_reg   <= s_action;
                        armed_reg <= s_armed;
                        accel_reg <= s_z_accel;
                        step_reg  <= '0;
                        if (s_action == ACT_OBSERVE) begin
                            if (ground_count_reg != 4'd0) begin
                                ground_count_reg <= ground_count_reg - 4'd1;
                                ground_cm_reg    <= 32'(s_baro_alt_cm);
                            end
                            baro_h_reg       <= bh_new;
                            flow_held_reg    <= fh_new;
                            bad_cnt_reg      <= bad_new[15:0];
                            baro_latched_reg <= latch_new;
                            prev_baro_reg    <= bh_new;
                            prev_flow_reg    <= fh_new;
                            flow_gains_reg   <= s_flow_ok && !latch_new;
                            // pick the difference to scale
                            if (s_flow_ok && !latch_new) begin
                                dvf_reg <= 32'(fh_new) - 32'(prev_flow_reg);
                            end else begin
                                dvf_reg <= sat(dvb);
                            end
                            state_reg <= ST_MUL;
                        end else if (s_action == ACT_NONE) begin
                            state_reg <= ST_OUT;
                        end else begin
                            if (s_action == ACT_FIX) begin
                                vref_reg <= clampl(PW'(vref_reg), VLIM);
                            end
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (rsp.done) begin
                        if (act_reg == ACT_OBSERVE) begin
                            vref_reg <= sat(vmul);
                        end else if (act_reg == ACT_INERTIAL) begin
                            // velocity first, then height from the new velocity
                            if (step_reg == 4'd0) evel_reg <= sat(PW'(evel_reg) + rnd);
                            else                  eh_reg   <= sat(PW'(eh_reg) + rnd);
                        end else begin
                            unique case (step_reg)
                                4'd0: href_reg <= sat(PW'(href_reg) + rnd);
                                4'd1: fh_reg   <= rnd[MUL_W-1:0];
                                4'd2: fv_reg   <= rnd[31:0];
                                4'd3: t_reg    <= rnd[31:0];
                                4'd4: ca_reg   <= clampl(PW'(ca_reg) + rnd, ALIM);
                                4'd5: eh_reg   <= sat(PW'(eh_reg) + rnd);
                                default: evel_reg <= sat(PW'(evel_reg) + rnd);
                            endcase
                        end
                        if (step_reg == last_step) begin
                            state_reg <= ST_OUT;
                        end else begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    m_valid      <= 1'b1;
                    m_z_speed    <= evel_reg;
                    m_z_position <= eh_reg;
                    m_using_baro <= !flow_gains_reg;
                    if (act_reg == ACT_FIX && (reset_pend_reg || !armed_reg)) begin
                        href_reg       <= '0;
                        vref_reg       <= '0;
                        eh_reg         <= '0;
                        reset_pend_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE && (!m_valid || m_ready))
        else $error("ready while busy");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |=> m_valid) else $error("result lost");
    a_corr_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        ca_reg <= ALIM && ca_reg >= -ALIM) else $error("correction out of range");

endmodule
